// ===== rtl/core/wsrm_pkg.sv =====
// Package for the weighted site region membership block.
// Holds the shared widths, function and register codes, the state type and the
// flag struct that passes from cell to cell. It depends on nothing else.
`timescale 1ns / 1ps

package wsrm_pkg;

  // Configuration port
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned COUNT_W   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_OWNER_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWNER_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWNER_RADIUS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOP            = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 3'd4;

  // Slop is unsigned Q4.12.
  localparam logic [CFG_W-1:0] SLOP_ONE = 16'd4096;

  // Item fields
  localparam int unsigned IDX_W = 4;
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // radius*slop is 32 bits; its square is 64 bits in Q.24.
  localparam int unsigned RAD_W      = 2 * CFG_W;
  localparam int unsigned SQ_W       = 2 * RAD_W;
  localparam int unsigned FRAC2_BITS = 24;
  localparam int unsigned THR_W      = SQ_W - FRAC2_BITS;

  localparam int unsigned OUT_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_HOLD
  } wsrm_state_e;

  // Query status that walks down the chain next to the query data.
  typedef struct packed {
    logic valid;
    logic outside;
    logic blocked;
  } wsrm_flags_t;

endpackage

// ===== rtl/core/wsrm_front.sv =====
// Owner circle test: two register stages of products and squares for one query.
// Feeds the first cell of the neighbour chain. Depends on wsrm_pkg.
`timescale 1ns / 1ps

module wsrm_front #(
  parameter int unsigned CoordBits = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [CoordBits-1:0]          px_i,
  input  logic [CoordBits-1:0]          py_i,
  input  logic [CoordBits-1:0]          owner_x_i,
  input  logic [CoordBits-1:0]          owner_y_i,
  input  logic [wsrm_pkg::CFG_W-1:0]    radius_i,
  input  logic [wsrm_pkg::CFG_W-1:0]    slop_i,
  output wsrm_pkg::wsrm_flags_t         flags_o,
  output logic [CoordBits-1:0]          px_o,
  output logic [CoordBits-1:0]          py_o,
  output logic [2*CoordBits+1:0]        own_d2_o,
  output logic [wsrm_pkg::THR_W-1:0]    thr_o
);

  localparam int unsigned DiffW = CoordBits + 1;
  localparam int unsigned D2W   = 2 * CoordBits + 2;

  // Stage one: differences and the two radius products.
  logic                              s1_valid_q, s1_valid_d;
  logic signed [DiffW-1:0]           dx_q, dx_d, dy_q, dy_d;
  logic [wsrm_pkg::RAD_W-1:0]        rad_q, rad_d, dlt_q, dlt_d;
  logic [CoordBits-1:0]              px1_q, py1_q;
  logic [wsrm_pkg::CFG_W-1:0]        slop_dist;

  // Stage two: squares.
  logic                              s2_valid_q, s2_valid_d;
  logic [D2W-1:0]                    own_d2_q, own_d2_d;
  logic [wsrm_pkg::SQ_W-1:0]         rad2_q, rad2_d, dlt2_q, dlt2_d;
  logic [CoordBits-1:0]              px2_q, py2_q;
  logic signed [D2W-1:0]             sqx, sqy;

  logic [wsrm_pkg::THR_W-1:0]        rad2_hi;
  logic [wsrm_pkg::FRAC2_BITS-1:0]   rad2_lo;
  logic [D2W-1:0]                    hi_cmp;
  logic                              hi_fits;

  always_comb begin
    slop_dist = (slop_i >= wsrm_pkg::SLOP_ONE) ? (slop_i - wsrm_pkg::SLOP_ONE)
                                               : (wsrm_pkg::SLOP_ONE - slop_i);
    s1_valid_d = start_i;
    dx_d  = $signed({px_i[CoordBits-1], px_i}) - $signed({owner_x_i[CoordBits-1], owner_x_i});
    dy_d  = $signed({py_i[CoordBits-1], py_i}) - $signed({owner_y_i[CoordBits-1], owner_y_i});
    rad_d = wsrm_pkg::RAD_W'(radius_i) * wsrm_pkg::RAD_W'(slop_i);
    dlt_d = wsrm_pkg::RAD_W'(radius_i) * wsrm_pkg::RAD_W'(slop_dist);
  end

  always_comb begin
    sqx        = dx_q * dx_q;
    sqy        = dy_q * dy_q;
    s2_valid_d = s1_valid_q;
    own_d2_d   = $unsigned(sqx) + $unsigned(sqy);
    rad2_d     = wsrm_pkg::SQ_W'(rad_q) * wsrm_pkg::SQ_W'(rad_q);
    dlt2_d     = wsrm_pkg::SQ_W'(dlt_q) * wsrm_pkg::SQ_W'(dlt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      rad_q <= rad_d;
      dlt_q <= dlt_d;
      px1_q <= px_i;
      py1_q <= py_i;
    end
    if (s1_valid_q) begin
      own_d2_q <= own_d2_d;
      rad2_q   <= rad2_d;
      dlt2_q   <= dlt2_d;
      px2_q    <= px1_q;
      py2_q    <= py1_q;
    end
  end

  // The point is inside when own_d2 * 2^24 < rad2, i.e. own_d2 is below the
  // upper part of rad2, or equal to it with a nonzero fraction left over.
  always_comb begin
    rad2_hi = rad2_q[wsrm_pkg::SQ_W-1:wsrm_pkg::FRAC2_BITS];
    rad2_lo = rad2_q[wsrm_pkg::FRAC2_BITS-1:0];
    if (D2W >= wsrm_pkg::THR_W) begin
      hi_fits = 1'b1;
      hi_cmp  = D2W'(rad2_hi);
    end else begin
      hi_fits = ((wsrm_pkg::THR_W'(own_d2_q) >> D2W) == '0) &&
                ((rad2_hi >> D2W) == '0);
      hi_cmp  = D2W'(rad2_hi);
    end
    flags_o.valid   = s2_valid_q;
    flags_o.blocked = 1'b0;
    if (hi_fits) begin
      flags_o.outside = !((own_d2_q < hi_cmp) ||
                          ((own_d2_q == hi_cmp) && (rad2_lo != '0)));
    end else begin
      // The upper part of rad2 exceeds any possible squared distance.
      flags_o.outside = 1'b0;
    end
  end

  assign px_o     = px2_q;
  assign py_o     = py2_q;
  assign own_d2_o = own_d2_q;
  assign thr_o    = dlt2_q[wsrm_pkg::SQ_W-1:wsrm_pkg::FRAC2_BITS];

endmodule

// ===== rtl/core/wsrm_cell.sv =====
// One neighbour cell: holds one neighbour position and tests the passing query
// against it, then hands the query to the next cell. Depends on wsrm_pkg.
`timescale 1ns / 1ps

module wsrm_cell #(
  parameter int unsigned CoordBits = 16,
  parameter int unsigned CellIdx   = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ld_en_i,
  input  logic [wsrm_pkg::IDX_W-1:0]    ld_idx_i,
  input  logic [CoordBits-1:0]          ld_x_i,
  input  logic [CoordBits-1:0]          ld_y_i,
  input  logic [wsrm_pkg::COUNT_W-1:0]  count_i,
  input  logic [CoordBits-1:0]          owner_x_i,
  input  logic [CoordBits-1:0]          owner_y_i,
  input  logic [wsrm_pkg::THR_W-1:0]    thr_i,
  input  wsrm_pkg::wsrm_flags_t         flags_i,
  input  logic [CoordBits-1:0]          px_i,
  input  logic [CoordBits-1:0]          py_i,
  input  logic [2*CoordBits+1:0]        own_d2_i,
  output wsrm_pkg::wsrm_flags_t         flags_o,
  output logic [CoordBits-1:0]          px_o,
  output logic [CoordBits-1:0]          py_o,
  output logic [2*CoordBits+1:0]        own_d2_o
);

  localparam int unsigned DiffW = CoordBits + 1;
  localparam int unsigned D2W   = 2 * CoordBits + 2;
  localparam int unsigned CmpW  = (D2W > wsrm_pkg::THR_W) ? D2W : wsrm_pkg::THR_W;

  logic [CoordBits-1:0]  nx_q, ny_q;
  logic                  ld_hit;
  logic                  in_use;
  logic                  at_owner;
  logic signed [DiffW-1:0] dx, dy;
  logic signed [D2W-1:0] sqx, sqy;
  logic [D2W-1:0]        oth_d2, gap;
  logic                  reject;

  wsrm_pkg::wsrm_flags_t flags_q, flags_d;
  logic [CoordBits-1:0]  px_q, py_q;
  logic [D2W-1:0]        own_d2_q;

  assign ld_hit = ld_en_i && (32'(ld_idx_i) == 32'(CellIdx));

  always_ff @(posedge clk_i) begin
    if (ld_hit) begin
      nx_q <= ld_x_i;
      ny_q <= ld_y_i;
    end
  end

  always_comb begin
    in_use   = 32'(count_i) > 32'(CellIdx);
    at_owner = (nx_q == owner_x_i) && (ny_q == owner_y_i);
    dx       = $signed({px_i[CoordBits-1], px_i}) - $signed({nx_q[CoordBits-1], nx_q});
    dy       = $signed({py_i[CoordBits-1], py_i}) - $signed({ny_q[CoordBits-1], ny_q});
    sqx      = dx * dx;
    sqy      = dy * dy;
    oth_d2   = $unsigned(sqx) + $unsigned(sqy);
    gap      = own_d2_i - oth_d2;
    // Rejected when this neighbour is nearer by more than the margin.
    reject   = flags_i.valid && !flags_i.outside && !flags_i.blocked && in_use &&
               !at_owner && (oth_d2 < own_d2_i) &&
               (CmpW'(gap) > CmpW'(thr_i));
    flags_d         = flags_i;
    flags_d.blocked = flags_i.blocked || reject;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= px_i;
    py_q     <= py_i;
    own_d2_q <= own_d2_i;
  end

  assign flags_o  = flags_q;
  assign px_o     = px_q;
  assign py_o     = py_q;
  assign own_d2_o = own_d2_q;

endmodule

// ===== rtl/core/weighted_site_region_membership.sv =====
// Weighted site region membership: top level with configuration, control and
// the chain of neighbour cells. Depends on wsrm_pkg, wsrm_front and wsrm_cell.
`timescale 1ns / 1ps

// A load transfer (tuser low) writes one neighbour entry and gives no result.
// A query transfer (tuser high) goes through the two-stage owner circle unit
// and then down a chain of MAX_NEIGHBOURS cells, one cell per cycle; the block
// takes no new item until the query's result has left the chain for the output
// register. The result waits in an output register, and the block takes new
// items while it waits. Configuration writes land at once and are meant for
// idle periods only. Neighbour entries hold nothing until loaded.
module weighted_site_region_membership #(
  parameter int unsigned MAX_NEIGHBOURS = 16,
  parameter int unsigned COORD_BITS     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes
  input  logic                                cfg_we_i,
  input  logic [wsrm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wsrm_pkg::CFG_W-1:0]          cfg_data_i,
  // Input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: entry_index, point_x, point_y, zero fill.
  input  logic [((wsrm_pkg::IDX_W+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // Fields: func.
  input  logic                                s_axis_tuser,
  // Results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: inside_res, out_of_range, blocked, zero fill.
  output logic [wsrm_pkg::OUT_W-1:0]          m_axis_tdata
);

  localparam int unsigned D2W = 2 * COORD_BITS + 2;
  localparam int unsigned PxLo = wsrm_pkg::IDX_W;
  localparam int unsigned PyLo = wsrm_pkg::IDX_W + COORD_BITS;

  // Configuration registers
  logic [wsrm_pkg::CFG_W-1:0]   owner_x_q, owner_y_q, radius_q, slop_q;
  logic [wsrm_pkg::COUNT_W-1:0] count_q;
  logic [COORD_BITS-1:0]        owner_x, owner_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_x_q <= '0;
      owner_y_q <= '0;
      radius_q  <= '0;
      slop_q    <= wsrm_pkg::SLOP_ONE;
      count_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wsrm_pkg::REG_OWNER_X:         owner_x_q <= cfg_data_i;
        wsrm_pkg::REG_OWNER_Y:         owner_y_q <= cfg_data_i;
        wsrm_pkg::REG_OWNER_RADIUS:    radius_q  <= cfg_data_i;
        wsrm_pkg::REG_SLOP:            slop_q    <= cfg_data_i;
        wsrm_pkg::REG_NEIGHBOUR_COUNT: count_q   <= wsrm_pkg::COUNT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The owner registers are taken as raw bits at coordinate width.
  assign owner_x = COORD_BITS'(owner_x_q);
  assign owner_y = COORD_BITS'(owner_y_q);

  // Input fields
  logic [wsrm_pkg::IDX_W-1:0] in_idx;
  logic [COORD_BITS-1:0]      in_px, in_py;
  logic                       in_xfer, ld_en, q_start;

  assign in_idx  = s_axis_tdata[wsrm_pkg::IDX_W-1:0];
  assign in_px   = s_axis_tdata[PxLo +: COORD_BITS];
  assign in_py   = s_axis_tdata[PyLo +: COORD_BITS];
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign ld_en   = in_xfer && (s_axis_tuser == wsrm_pkg::FUNC_LOAD);
  assign q_start = in_xfer && (s_axis_tuser == wsrm_pkg::FUNC_QUERY);

  // Chain links: link 0 comes from the owner circle unit.
  wsrm_pkg::wsrm_flags_t      ch_flags  [MAX_NEIGHBOURS+1];
  logic [COORD_BITS-1:0]      ch_px     [MAX_NEIGHBOURS+1];
  logic [COORD_BITS-1:0]      ch_py     [MAX_NEIGHBOURS+1];
  logic [D2W-1:0]             ch_own_d2 [MAX_NEIGHBOURS+1];
  logic [wsrm_pkg::THR_W-1:0] thr;

  wsrm_front #(
    .CoordBits (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (q_start),
    .px_i      (in_px),
    .py_i      (in_py),
    .owner_x_i (owner_x),
    .owner_y_i (owner_y),
    .radius_i  (radius_q),
    .slop_i    (slop_q),
    .flags_o   (ch_flags[0]),
    .px_o      (ch_px[0]),
    .py_o      (ch_py[0]),
    .own_d2_o  (ch_own_d2[0]),
    .thr_o     (thr)
  );

  for (genvar g = 0; g < MAX_NEIGHBOURS; g++) begin : g_cell
    wsrm_cell #(
      .CoordBits (COORD_BITS),
      .CellIdx   (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ld_en_i   (ld_en),
      .ld_idx_i  (in_idx),
      .ld_x_i    (in_px),
      .ld_y_i    (in_py),
      .count_i   (count_q),
      .owner_x_i (owner_x),
      .owner_y_i (owner_y),
      .thr_i     (thr),
      .flags_i   (ch_flags[g]),
      .px_i      (ch_px[g]),
      .py_i      (ch_py[g]),
      .own_d2_i  (ch_own_d2[g]),
      .flags_o   (ch_flags[g+1]),
      .px_o      (ch_px[g+1]),
      .py_o      (ch_py[g+1]),
      .own_d2_o  (ch_own_d2[g+1])
    );
  end

  // Control
  wsrm_pkg::wsrm_state_e state_q, state_d;
  wsrm_pkg::wsrm_flags_t tail;
  logic                  res_outside_q, res_blocked_q;
  logic                  res_cap;
  logic                  out_free, out_load;
  logic                  out_valid_q, out_valid_d;
  logic [wsrm_pkg::OUT_W-1:0] out_data_q, out_data_d;

  assign tail     = ch_flags[MAX_NEIGHBOURS];
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wsrm_pkg::ST_IDLE: if (q_start) state_d = wsrm_pkg::ST_BUSY;
      wsrm_pkg::ST_BUSY: if (tail.valid) state_d = wsrm_pkg::ST_HOLD;
      wsrm_pkg::ST_HOLD: if (out_free) state_d = wsrm_pkg::ST_IDLE;
      default:           state_d = wsrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    res_cap       = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      wsrm_pkg::ST_IDLE: s_axis_tready = 1'b1;
      wsrm_pkg::ST_BUSY: res_cap       = tail.valid;
      wsrm_pkg::ST_HOLD: out_load      = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d   = 1'b1;
      out_data_d    = '0;
      out_data_d[0] = !res_outside_q && !res_blocked_q;
      out_data_d[1] = res_outside_q;
      out_data_d[2] = res_blocked_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsrm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (res_cap) begin
      res_outside_q <= tail.outside;
      res_blocked_q <= tail.blocked;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
